// ----- design/roqt_pkg.sv -----
// Shared types, codes and constants of the rectangle overlap query table.
package roqt_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_COMMIT = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_FIND   = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_MATCH   = 3'd1;
   localparam logic [2:0] ST_NOMATCH = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_DUP     = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   typedef struct packed {
      logic [1:0]         kind;
      logic [63:0]        item_key;
      logic [63:0]        item_child;
      logic signed [31:0] left_x;
      logic signed [31:0] top_y;
      logic [31:0]        box_width;
      logic [31:0]        box_height;
      logic [31:0]        content_width;
      logic [31:0]        content_height;
      logic signed [31:0] scroll_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [63:0]        out_key;
      logic [63:0]        out_child;
      logic signed [31:0] out_left;
      logic signed [31:0] out_top;
      logic [31:0]        out_width;
      logic [31:0]        out_height;
      logic [31:0]        out_source_width;
      logic [31:0]        out_source_height;
      logic signed [31:0] out_scroll;
      logic               last;
   } rsp_type;

   typedef struct packed {
      req_type            req;
      logic               fields_ok;
      logic               view_ok;
      logic signed [33:0] view_right;
      logic signed [33:0] view_bottom;
   } cmd_type;

   typedef struct packed {
      logic [63:0]        key;
      logic [63:0]        child;
      logic signed [31:0] left;
      logic signed [31:0] top;
      logic [31:0]        width;
      logic [31:0]        height;
      logic [31:0]        src_width;
      logic [31:0]        src_height;
      logic signed [31:0] scroll;
      logic               fields_ok;
   } entry_type;

endpackage

// ----- design/roqt_front.sv -----
// Front end: accepts request items, classifies them and queues them for the engine.
module roqt_front
   import roqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_take,
   output cmd_type cmd_data
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       do_wr, do_rd;

   always_comb begin
      cls.req = req_data;
      cls.fields_ok = (req_data.item_key != 64'd0) && (req_data.item_child != 64'd0) &&
                      (req_data.box_width != 32'd0) && (req_data.box_height != 32'd0) &&
                      (req_data.content_width != 32'd0) &&
                      (req_data.content_height != 32'd0) &&
                      !req_data.scroll_offset[31];
      cls.view_ok = (req_data.box_width != 32'd0) && (req_data.box_height != 32'd0);
      cls.view_right = {{2{req_data.left_x[31]}}, req_data.left_x} +
                       $signed({2'b00, req_data.box_width});
      cls.view_bottom = {{2{req_data.top_y[31]}}, req_data.top_y} +
                        $signed({2'b00, req_data.box_height});
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_wr     = push && !full;
   assign do_rd     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- design/roqt_rsp_queue.sv -----
// Result queue: holds finished result items until they are popped.
module roqt_rsp_queue
   import roqt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   output logic    room,
   output logic    empty,
   input  logic    pop,
   output rsp_type rd_data
);

   rsp_type    buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign room    = (cnt_ff != 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = buf_ff[rd_ptr_ff];
   assign do_wr   = wr_en && room;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         buf_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- design/roqt_engine.sv -----
// Back end: entry and order memories with the sequencer for load, commit, query and find.
module roqt_engine
   import roqt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_take,
   input  cmd_type cmd_data,
   input  logic    rsp_room,
   output logic    rsp_push,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_EMIT = 5'd1;
   localparam logic [4:0] S_CI   = 5'd2;
   localparam logic [4:0] S_CIW  = 5'd3;
   localparam logic [4:0] S_CIU  = 5'd4;
   localparam logic [4:0] S_CJ   = 5'd5;
   localparam logic [4:0] S_CJW  = 5'd6;
   localparam logic [4:0] S_CJU  = 5'd7;
   localparam logic [4:0] S_SI   = 5'd8;
   localparam logic [4:0] S_SIW  = 5'd9;
   localparam logic [4:0] S_SJ   = 5'd10;
   localparam logic [4:0] S_SJW  = 5'd11;
   localparam logic [4:0] S_SJU  = 5'd12;
   localparam logic [4:0] S_SW   = 5'd13;
   localparam logic [4:0] S_QP   = 5'd14;
   localparam logic [4:0] S_QPW  = 5'd15;
   localparam logic [4:0] S_QE   = 5'd16;
   localparam logic [4:0] S_QEW  = 5'd17;
   localparam logic [4:0] S_QEU  = 5'd18;
   localparam logic [4:0] S_QNX  = 5'd19;
   localparam logic [4:0] S_FI   = 5'd20;
   localparam logic [4:0] S_FIW  = 5'd21;
   localparam logic [4:0] S_FIU  = 5'd22;

   entry_type       ent_ff [CAPACITY];
   logic [IDX_W-1:0] ord_ff [CAPACITY];

   logic [4:0]       state_ff, state_in;
   logic [4:0]       ret_ff, ret_in;
   cmd_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ready_ff, ready_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] rank_ff, rank_in;
   entry_type        pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          res_ff, res_in;
   logic [IDX_W-1:0] addr_a_ff, addr_a_in;
   logic [IDX_W-1:0] addr_b_ff, addr_b_in;
   logic [IDX_W-1:0] ord_addr_ff, ord_addr_in;
   entry_type        rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0] ord_rd_ff;

   logic             ent_we;
   logic [IDX_W-1:0] ent_waddr;
   entry_type        ent_wdata;
   logic             ord_we;
   logic [IDX_W-1:0] ord_waddr;
   logic [IDX_W-1:0] ord_wdata;

   logic [CNT_W-1:0] i_inc, j_inc, base;
   logic             b_before_a, hit;
   logic signed [33:0] ent_x, ent_y, ent_right, ent_bottom, view_x, view_y;

   function automatic rsp_type status_rsp(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type entry_rsp(input entry_type e, input logic lst);
      rsp_type r;
      r.status            = ST_MATCH;
      r.out_key           = e.key;
      r.out_child         = e.child;
      r.out_left          = e.left;
      r.out_top           = e.top;
      r.out_width         = e.width;
      r.out_height        = e.height;
      r.out_source_width  = e.src_width;
      r.out_source_height = e.src_height;
      r.out_scroll        = e.scroll;
      r.last              = lst;
      return r;
   endfunction

   assign i_inc = i_ff + ONE_CNT;
   assign j_inc = j_ff + ONE_CNT;
   assign base  = ready_ff ? '0 : count_ff;

   assign b_before_a = (rd_b_ff.top < rd_a_ff.top) ||
                       ((rd_b_ff.top == rd_a_ff.top) && (rd_b_ff.key < rd_a_ff.key));

   assign ent_x      = {{2{rd_a_ff.left[31]}}, rd_a_ff.left};
   assign ent_y      = {{2{rd_a_ff.top[31]}}, rd_a_ff.top};
   assign ent_right  = ent_x + $signed({2'b00, rd_a_ff.width});
   assign ent_bottom = ent_y + $signed({2'b00, rd_a_ff.height});
   assign view_x     = {{2{cmd_ff.req.left_x[31]}}, cmd_ff.req.left_x};
   assign view_y     = {{2{cmd_ff.req.top_y[31]}}, cmd_ff.req.top_y};
   assign hit = (ent_x < cmd_ff.view_right) && (ent_right > view_x) &&
                (ent_y < cmd_ff.view_bottom) && (ent_bottom > view_y);

   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_push = (state_ff == S_EMIT) && rsp_room;
   assign rsp_data = res_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      ready_in      = ready_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rank_in       = rank_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      res_in        = res_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      ord_addr_in   = ord_addr_ff;
      ent_we        = 1'b0;
      ent_waddr     = base[IDX_W-1:0];
      ent_wdata.key        = cmd_data.req.item_key;
      ent_wdata.child      = cmd_data.req.item_child;
      ent_wdata.left       = cmd_data.req.left_x;
      ent_wdata.top        = cmd_data.req.top_y;
      ent_wdata.width      = cmd_data.req.box_width;
      ent_wdata.height     = cmd_data.req.box_height;
      ent_wdata.src_width  = cmd_data.req.content_width;
      ent_wdata.src_height = cmd_data.req.content_height;
      ent_wdata.scroll     = cmd_data.req.scroll_offset;
      ent_wdata.fields_ok  = cmd_data.fields_ok;
      ord_we        = 1'b0;
      ord_waddr     = rank_ff[IDX_W-1:0];
      ord_wdata     = i_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in        = cmd_data;
               i_in          = '0;
               j_in          = '0;
               pend_valid_in = 1'b0;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
               case (cmd_data.req.kind)
                  KIND_LOAD: begin
                     ready_in = 1'b0;
                     if (base >= CAP_CNT) begin
                        count_in = base;
                        res_in   = status_rsp(ST_FULL);
                     end else begin
                        ent_we   = 1'b1;
                        count_in = base + ONE_CNT;
                        res_in   = status_rsp(ST_OK);
                     end
                  end
                  KIND_COMMIT: begin
                     if (count_ff == '0) begin
                        ready_in = 1'b1;
                        res_in   = status_rsp(ST_OK);
                     end else begin
                        state_in = S_CI;
                     end
                  end
                  KIND_QUERY: begin
                     if (ready_ff && cmd_data.view_ok && (count_ff != '0)) begin
                        state_in = S_QP;
                     end else begin
                        res_in = status_rsp(ST_NOMATCH);
                     end
                  end
                  default: begin
                     if (ready_ff && (count_ff != '0)) begin
                        state_in = S_FI;
                     end else begin
                        res_in = status_rsp(ST_NOMATCH);
                     end
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (rsp_room) begin
               state_in = ret_ff;
            end
         end
         S_CI: begin
            addr_a_in = i_ff[IDX_W-1:0];
            j_in      = '0;
            state_in  = S_CIW;
         end
         S_CIW: state_in = S_CIU;
         S_CIU: begin
            if (!rd_a_ff.fields_ok) begin
               count_in = '0;
               ready_in = 1'b0;
               res_in   = status_rsp(ST_INVALID);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else if (i_ff != '0) begin
               state_in = S_CJ;
            end else if (i_inc == count_ff) begin
               i_in     = '0;
               state_in = S_SI;
            end else begin
               i_in     = i_inc;
               state_in = S_CI;
            end
         end
         S_CJ: begin
            addr_b_in = j_ff[IDX_W-1:0];
            state_in  = S_CJW;
         end
         S_CJW: state_in = S_CJU;
         S_CJU: begin
            if ((rd_b_ff.key == rd_a_ff.key) || (rd_b_ff.child == rd_a_ff.child)) begin
               count_in = '0;
               ready_in = 1'b0;
               res_in   = status_rsp(ST_DUP);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else if (j_inc != i_ff) begin
               j_in     = j_inc;
               state_in = S_CJ;
            end else if (i_inc == count_ff) begin
               i_in     = '0;
               state_in = S_SI;
            end else begin
               i_in     = i_inc;
               state_in = S_CI;
            end
         end
         S_SI: begin
            addr_a_in = i_ff[IDX_W-1:0];
            rank_in   = '0;
            j_in      = '0;
            state_in  = S_SIW;
         end
         S_SIW: state_in = S_SJ;
         S_SJ: begin
            addr_b_in = j_ff[IDX_W-1:0];
            state_in  = S_SJW;
         end
         S_SJW: state_in = S_SJU;
         S_SJU: begin
            if (b_before_a) begin
               rank_in = rank_ff + ONE_CNT;
            end
            if (j_inc == count_ff) begin
               state_in = S_SW;
            end else begin
               j_in     = j_inc;
               state_in = S_SJ;
            end
         end
         S_SW: begin
            ord_we = 1'b1;
            if (i_inc == count_ff) begin
               ready_in = 1'b1;
               res_in   = status_rsp(ST_OK);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               i_in     = i_inc;
               state_in = S_SI;
            end
         end
         S_QP: begin
            ord_addr_in = i_ff[IDX_W-1:0];
            state_in    = S_QPW;
         end
         S_QPW: state_in = S_QE;
         S_QE: begin
            addr_a_in = ord_rd_ff;
            state_in  = S_QEW;
         end
         S_QEW: state_in = S_QEU;
         S_QEU: begin
            state_in = S_QNX;
            if (hit) begin
               pend_in       = rd_a_ff;
               pend_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  res_in   = entry_rsp(pend_ff, 1'b0);
                  ret_in   = S_QNX;
                  state_in = S_EMIT;
               end
            end
         end
         S_QNX: begin
            if (i_inc == count_ff) begin
               res_in   = pend_valid_ff ? entry_rsp(pend_ff, 1'b1) : status_rsp(ST_NOMATCH);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               i_in     = i_inc;
               state_in = S_QP;
            end
         end
         S_FI: begin
            addr_a_in = i_ff[IDX_W-1:0];
            state_in  = S_FIW;
         end
         S_FIW: state_in = S_FIU;
         S_FIU: begin
            if (rd_a_ff.key == cmd_ff.req.item_key) begin
               res_in   = entry_rsp(rd_a_ff, 1'b1);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else if (i_inc == count_ff) begin
               res_in   = status_rsp(ST_NOMATCH);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               i_in     = i_inc;
               state_in = S_FI;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         count_ff      <= '0;
         ready_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         count_ff      <= count_in;
         ready_ff      <= ready_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      rank_ff     <= rank_in;
      pend_ff     <= pend_in;
      res_ff      <= res_in;
      addr_a_ff   <= addr_a_in;
      addr_b_ff   <= addr_b_in;
      ord_addr_ff <= ord_addr_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_ff[ent_waddr] <= ent_wdata;
      end
      rd_a_ff <= ent_ff[addr_a_ff];
      rd_b_ff <= ent_ff[addr_b_ff];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_ff[ord_waddr] <= ord_wdata;
      end
      ord_rd_ff <= ord_ff[ord_addr_ff];
   end

endmodule

// ----- design/rect_overlap_query_table.sv -----
// Top level of the rectangle overlap query table.
// The block holds up to CAPACITY rectangles in a two-read-port entry memory and
// works on one item at a time, walking that memory one entry per step. A load
// writes one entry unless the table is full. A commit checks the entries in load
// order and then ranks them by top edge and key. A viewport query walks the sorted
// order and can wait while the result queue stays full, and a find walks the
// entries in load order. Items wait in a two-deep queue in front of the engine
// and results in a two-deep queue behind it. The memories start with unknown
// contents; only loaded entries are ever read, so no clearing pass runs after
// reset.
module rect_overlap_query_table
   import roqt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    cmd_valid, cmd_take;
   cmd_type cmd_data;
   logic    rsp_room, rsp_push;
   rsp_type eng_rsp;

   roqt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data)
   );

   roqt_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_data  (cmd_data),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_data  (eng_rsp)
   );

   roqt_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (eng_rsp),
      .room    (rsp_room),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_data)
   );

endmodule
